### design/integer_logic_shift_divide_alu_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef INTEGER_LOGIC_SHIFT_DIVIDE_ALU_MACROS_SVH
`define INTEGER_LOGIC_SHIFT_DIVIDE_ALU_MACROS_SVH

// Checked only while reset is released.
`define ISDALU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ISDALU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/isdalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdalu_pkg
// Shared widths, operation codes and pipeline word types of the integer ALU.
// ----------------------------------------------------------------------------
package isdalu_pkg;

	localparam int DW      = 32;
	localparam int OPW     = 4;
	localparam int SHW     = $clog2(DW);
	localparam int LATENCY = DW + 4;

	typedef logic [OPW-1:0] op_t;

	localparam op_t OP_AND  = 4'd0;
	localparam op_t OP_LAND = 4'd1;
	localparam op_t OP_OR   = 4'd2;
	localparam op_t OP_LOR  = 4'd3;
	localparam op_t OP_SHL  = 4'd4;
	localparam op_t OP_SHR  = 4'd5;
	localparam op_t OP_REM  = 4'd6;
	localparam op_t OP_MOD  = 4'd7;
	localparam op_t OP_DIV  = 4'd8;

	typedef struct packed {
		op_t           op;
		logic          qneg;
		logic          rneg;
		logic          dpos;
		logic          aneg;
		logic [DW-1:0] divisor;
		logic [DW-1:0] other;
	} side_t;

	typedef struct packed {
		logic          valid;
		logic [DW-1:0] rem;
		logic [DW-1:0] work;
		logic [DW-1:0] ud;
		side_t         side;
	} cell_t;

endpackage

### design/integer_logic_shift_divide_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer logic, shift and divide ALU
// Bitwise, logical, shift, remainder, modulo and floor-style divide on two
// signed operands, with a pipelined restoring divider built as a cell chain.
// ----------------------------------------------------------------------------
// Usage:
// A word (left_operand, right_operand) is taken at a rising edge with start
// high and busy low. busy stays low, so a new word may enter every cycle.
// The operation comes from the register written with operation_we/operation;
// write it only while no word is in flight.
// Each word gives one result word on result, marked by done for exactly one
// cycle, after two front-end stages, one divider cell per operand bit (32)
// and two back-end stages. All operations pass through the same pipeline,
// so results leave in order at one word per cycle.
// The receiver cannot stall; done is a strobe and result must be taken then.
// Reset clears the operation register to bitwise and and empties the
// pipeline; words in flight are dropped.
// ----------------------------------------------------------------------------
module integer_logic_shift_divide_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [isdalu_pkg::DW-1:0]     left_operand,
	input  logic [isdalu_pkg::DW-1:0]     right_operand,
	input  logic                          operation_we,
	input  logic [isdalu_pkg::OPW-1:0]    operation,
	output logic                          done,
	output logic [isdalu_pkg::DW-1:0]     result
);
	import isdalu_pkg::*;

	op_t   operation_q;
	cell_t chain [DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q <= OP_AND;
		end else if (operation_we) begin
			operation_q <= operation;
		end
	end

	assign busy = 1'b0;

	isdalu_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (start && !busy),
		.op     (operation_q),
		.a      (left_operand),
		.b      (right_operand),
		.out_q  (chain[0])
	);

	for (genvar i = 0; i < DW; i++) begin : g_cell
		isdalu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.in_c   (chain[i]),
			.out_q  (chain[i+1])
		);
	end

	isdalu_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.in_c   (chain[DW]),
		.done   (done),
		.result (result)
	);

endmodule

### design/isdalu_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdalu_prep
// Two-stage front end: divisor substitution, sign adjustment of the operands,
// the non-dividing operations, and operand magnitudes for the divider chain.
// ----------------------------------------------------------------------------
module isdalu_prep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  isdalu_pkg::op_t                op,
	input  logic [isdalu_pkg::DW-1:0]      a,
	input  logic [isdalu_pkg::DW-1:0]      b,
	output isdalu_pkg::cell_t              out_q
);
	import isdalu_pkg::*;

	logic [DW-1:0] d;
	logic [DW-1:0] a_adj;
	logic [DW-1:0] d_adj;
	logic [DW-1:0] other;

	logic          valid_s1;
	op_t           op_s1;
	logic [DW-1:0] a_s1;
	logic [DW-1:0] d_s1;
	logic          dpos_s1;
	logic          aneg_s1;
	logic [DW-1:0] other_s1;

	always_comb begin
		d = (b == '0) ? DW'(1) : b;
		a_adj = a;
		d_adj = d;
		if (op == OP_DIV && d[DW-1]) begin
			if (a[DW-1]) begin
				a_adj = -a;
				d_adj = -d;
			end else begin
				a_adj = a + d - DW'(1);
			end
		end
		case (op)
			OP_AND:  other = a & b;
			OP_LAND: other = DW'((a != '0) && (b != '0));
			OP_OR:   other = a | b;
			OP_LOR:  other = DW'((a != '0) || (b != '0));
			OP_SHL:  other = a << b[SHW-1:0];
			OP_SHR:  other = $unsigned($signed(a) >>> b[SHW-1:0]);
			default: other = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= op;
		a_s1     <= a_adj;
		d_s1     <= d_adj;
		dpos_s1  <= !d[DW-1];
		aneg_s1  <= a[DW-1];
		other_s1 <= other;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q.valid        <= valid_s1;
			out_q.rem          <= '0;
			out_q.work         <= a_s1[DW-1] ? -a_s1 : a_s1;
			out_q.ud           <= d_s1[DW-1] ? -d_s1 : d_s1;
			out_q.side.op      <= op_s1;
			out_q.side.qneg    <= a_s1[DW-1] ^ d_s1[DW-1];
			out_q.side.rneg    <= a_s1[DW-1];
			out_q.side.dpos    <= dpos_s1;
			out_q.side.aneg    <= aneg_s1;
			out_q.side.divisor <= d_s1;
			out_q.side.other   <= other_s1;
		end
	end

endmodule

### design/isdalu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdalu_cell
// One restoring division step: shifts in one dividend bit, trial-subtracts
// the divisor and shifts out one quotient bit to the next cell.
// ----------------------------------------------------------------------------
module isdalu_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  isdalu_pkg::cell_t in_c,
	output isdalu_pkg::cell_t out_q
);
	import isdalu_pkg::*;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {in_c.rem, in_c.work[DW-1]};
		diff  = trial - {1'b0, in_c.ud};
		ge    = !diff[DW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q.valid <= in_c.valid;
			out_q.rem   <= ge ? diff[DW-1:0] : trial[DW-1:0];
			out_q.work  <= {in_c.work[DW-2:0], ge};
			out_q.ud    <= in_c.ud;
			out_q.side  <= in_c.side;
		end
	end

endmodule

### design/isdalu_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdalu_post
// Two-stage back end: restores the signs of quotient and remainder, applies
// the floor and non-negative remainder corrections and selects the result.
// ----------------------------------------------------------------------------
module isdalu_post (
	input  logic                      clk,
	input  logic                      arst_n,
	input  isdalu_pkg::cell_t         in_c,
	output logic                      done,
	output logic [isdalu_pkg::DW-1:0] result
);
	import isdalu_pkg::*;

	logic          valid_s1;
	side_t         side_s1;
	logic [DW-1:0] quot_s1;
	logic [DW-1:0] remt_s1;
	logic          rnz_s1;
	logic [DW-1:0] sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_c.side;
		quot_s1 <= in_c.side.qneg ? -in_c.work : in_c.work;
		remt_s1 <= in_c.side.rneg ? -in_c.rem : in_c.rem;
		rnz_s1  <= in_c.rem != '0;
	end

	always_comb begin
		case (side_s1.op)
			OP_REM: sel = remt_s1;
			OP_MOD: sel = (side_s1.dpos && remt_s1[DW-1]) ? remt_s1 + side_s1.divisor
				: remt_s1;
			OP_DIV: sel = (side_s1.dpos && side_s1.aneg && rnz_s1) ? quot_s1 - DW'(1)
				: quot_s1;
			default: sel = side_s1.other;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result <= sel;
	end

endmodule

### design/isdalu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isdalu_checker
// Port-level checks of the ALU: fixed latency between accepted and delivered
// words, and a quiet output during reset.
// ----------------------------------------------------------------------------
`include "integer_logic_shift_divide_alu_macros.svh"

module isdalu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import isdalu_pkg::*;

	`ISDALU_ASSERT(a_done_has_source, done |-> $past(start && !busy, LATENCY), "Result word without an accepted word.")
	`ISDALU_ASSERT(a_word_delivered, (arst_n && start && !busy) |-> ##LATENCY done, "Accepted word not delivered on time.")
	`ISDALU_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |-> (done !== 1'b1), "Result strobe during reset.")

endmodule

bind integer_logic_shift_divide_alu isdalu_checker u_isdalu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

### dv/integer_logic_shift_divide_alu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer logic, shift and divide ALU testbench
// Walks a short list of directed words, then random words in chunks, each
// chunk under its own operation code. Each accepted word is predicted by its
// directed row or a floor-division ALU model, matched in order to result strobes.
// ----------------------------------------------------------------------------
module integer_logic_shift_divide_alu_test;
	import isdalu_pkg::*;

	localparam op_t OP_UNUSED_FIRST = 4'd9;
	localparam op_t OP_UNUSED_LAST  = 4'd15;
	localparam int  DIRECTED_COUNT  = 25;
	localparam int  CHUNKS_PER_PHASE = 7;
	localparam int  WORDS_PER_CHUNK  = 30;
	localparam int  STALL_LIMIT      = 500;

	typedef struct {
		op_t           op;
		logic [DW-1:0] lhs;
		logic [DW-1:0] rhs;
		logic [DW-1:0] value;
	} result_word_t;

	typedef struct {
		op_t           op;
		logic [DW-1:0] lhs;
		logic [DW-1:0] rhs;
		logic          typed;
		logic [DW-1:0] want;
	} directed_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [DW-1:0] left_operand = '0;
	logic [DW-1:0] right_operand = '0;
	logic          operation_we = 1'b0;
	logic [OPW-1:0] operation = '0;
	logic          done;
	logic [DW-1:0] result;

	result_word_t  pending_results [$];
	result_word_t  oldest;
	op_t           active_op = OP_AND;
	int            mismatch_count = 0;
	int            sender_idle_pct = 0;
	int            quiet_cycles = 0;

	directed_row_t directed_rows [DIRECTED_COUNT] = '{
		'{OP_AND,  32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b1, 32'h0F0F_0F0F},
		'{OP_AND,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_LAND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_LAND, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001},
		'{OP_OR,   32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{OP_LOR,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{OP_LOR,  32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001},
		'{OP_SHL,  32'h0000_0001, 32'd31,        1'b1, 32'h8000_0000},
		'{OP_SHL,  32'hFFFF_FFFF, 32'd32,        1'b1, 32'hFFFF_FFFF},
		'{OP_SHL,  32'h1234_5678, 32'hFFFF_FFE4, 1'b0, 32'h0},
		'{OP_SHR,  32'h8000_0000, 32'd31,        1'b1, 32'hFFFF_FFFF},
		'{OP_SHR,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_REM,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_REM,  32'h0000_0007, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{OP_REM,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFF},
		'{OP_MOD,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'h0000_0001},
		'{OP_MOD,  32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF},
		'{OP_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
		'{OP_DIV,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFC},
		'{OP_DIV,  32'h0000_0007, 32'h0000_0000, 1'b1, 32'h0000_0007},
		'{OP_DIV,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFE},
		'{OP_DIV,  32'h0000_0007, 32'hFFFF_FFFE, 1'b0, 32'h0},
		'{OP_DIV,  32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
		'{OP_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_UNUSED_LAST,  32'h1234_5678, 32'h0000_0001, 1'b1, 32'h0000_0000}
	};

	integer_logic_shift_divide_alu DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.left_operand(left_operand),
		.right_operand(right_operand),
		.operation_we(operation_we),
		.operation(operation),
		.done(done),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [DW-1:0] floor_alu_result(op_t op, logic [DW-1:0] lhs,
			logic [DW-1:0] rhs);
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] a_mag;
		logic signed [DW-1:0] d_mag;
		logic signed [DW-1:0] a_adj;
		longint               la;
		longint               ld;
		longint               lx;
		longint               ly;
		longint               q;
		longint               r;
		logic [DW-1:0]        out;
		a = lhs;
		d = (rhs == '0) ? 32'sd1 : rhs;
		la = a;
		ld = d;
		r = la % ld;
		q = 0;
		out = '0;
		case (op)
			OP_AND:  out = lhs & rhs;
			OP_LAND: out = {31'd0, (lhs != '0) && (rhs != '0)};
			OP_OR:   out = lhs | rhs;
			OP_LOR:  out = {31'd0, (lhs != '0) || (rhs != '0)};
			OP_SHL:  out = lhs << rhs[4:0];
			OP_SHR:  out = a >>> rhs[4:0];
			OP_REM:  out = r[DW-1:0];
			OP_MOD: begin
				if (ld > 0 && r < 0)
					r = r + ld;
				out = r[DW-1:0];
			end
			OP_DIV: begin
				if (ld > 0) begin
					q = la / ld;
					if (la < 0 && r != 0)
						q = q - 1;
				end else if (la < 0) begin
					// Both magnitudes wrap, so the most negative value stays negative.
					a_mag = -a;
					d_mag = -d;
					lx = a_mag;
					ly = d_mag;
					q = lx / ly;
				end else begin
					a_adj = a + d - 32'sd1;
					lx = a_adj;
					q = lx / ld;
				end
				out = q[DW-1:0];
			end
			default: out = '0;
		endcase
		return out;
	endfunction

	function automatic logic [DW-1:0] pick_operand();
		logic [DW-1:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = 32'($urandom_range(0, 18)) - 32'd9;
			2: begin
				case ($urandom_range(0, 4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					default: v = 32'h0000_0001;
				endcase
			end
			3, 4: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic program_operation(op_t op);
		wait_drained();
		operation_we <= 1'b1;
		operation <= op;
		@(posedge clk);
		operation_we <= 1'b0;
		active_op = op;
	endtask

	task automatic send_word(logic [DW-1:0] lhs, logic [DW-1:0] rhs, logic typed,
			logic [DW-1:0] want);
		result_word_t w;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
		start <= 1'b1;
		left_operand <= lhs;
		right_operand <= rhs;
		do
			@(posedge clk);
		while (busy);
		w.op = active_op;
		w.lhs = lhs;
		w.rhs = rhs;
		w.value = typed ? want : floor_alu_result(active_op, lhs, rhs);
		pending_results.push_back(w);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result %h with no word outstanding", $time, result);
			end else begin
				oldest = pending_results.pop_front();
				if (result !== oldest.value) begin
					mismatch_count++;
					$display("%0t: op %0d lhs %h rhs %h expected %h actual %h", $time,
						oldest.op, oldest.lhs, oldest.rhs, oldest.value, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("integer_logic_shift_divide_alu_test: errors");
			$finish;
		end
	end

	initial begin
		op_t chunk_op;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows run under the reset operation, with no register write.
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			if (directed_rows[i].op != active_op)
				program_operation(directed_rows[i].op);
			send_word(directed_rows[i].lhs, directed_rows[i].rhs, directed_rows[i].typed,
				directed_rows[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 68 : 0;
			for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
				if (phase * CHUNKS_PER_PHASE + c < 16)
					chunk_op = op_t'(phase * CHUNKS_PER_PHASE + c);
				else
					chunk_op = op_t'($urandom_range(0, 15));
				program_operation(chunk_op);
				for (int n = 0; n < WORDS_PER_CHUNK; n++)
					send_word(pick_operand(), pick_operand(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (LATENCY + 2)
			@(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("integer_logic_shift_divide_alu_test: clean");
		else
			$display("integer_logic_shift_divide_alu_test: errors");
		$finish;
	end

endmodule
